FILE: rtl/bmhpq_pkg.sv
// shared types and constants for the binary max-heap priority queue
// no dependencies
package bmhpq_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 32;
  localparam int unsigned TagW     = 16;
  localparam int unsigned OccW     = 11;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpClear  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e              op;
    logic [KeyW-1:0]  key;
    logic [TagW-1:0]  tag;
  } cmd_t;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [TagW-1:0]   tag;
    status_e           status;
    logic              now_empty;
    logic              now_full;
    logic [OccW-1:0]   occupancy;
  } res_t;

endpackage

FILE: rtl/bmhpq_front.sv
// front end: accepts items and queues classified commands
// depends on bmhpq_pkg
module bmhpq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic signed [31:0] new_key_i,
  input  logic [15:0]       new_tag_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output bmhpq_pkg::cmd_t   cmd_o
);
  import bmhpq_pkg::*;

  // two-entry queue
  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       c;

  always_comb begin
    c.key = new_key_i;
    c.tag = new_tag_i;
    c.op  = op_e'(operation_i);
  end

  assign in_ready_o  = cnt_q != 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = mem_q[rptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("bad queue count");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop lost");

endmodule

FILE: rtl/bmhpq_back.sv
// back end: heap memory and sift sequencer, one command at a time
// depends on bmhpq_pkg
module bmhpq_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  bmhpq_pkg::cmd_t  cmd_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output bmhpq_pkg::res_t  res_o
);
  import bmhpq_pkg::*;

  localparam int unsigned SlotW = KeyW + TagW;

  typedef enum logic [2:0] {
    SIdle, SUpRd, SUpCmp, SRmLast, SRmGot, SDnRd, SDnCmp, SDone
  } state_e;

  // heap memory, slot i at address i-1
  logic [SlotW-1:0] mem [Capacity];
  logic [SlotW-1:0] rd_q;

  state_e            state_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] pos_q;    // hole for the moving entry, 1-based
  logic [SlotW-1:0]  node_q;   // moving entry
  logic [SlotW-1:0]  left_q;
  res_t              res_q;
  logic              rvalid_q;

  logic              rd_en, wr_en;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic [SlotW-1:0]  wr_data;
  logic [CountW:0]   lchild;
  logic [CountW-1:0] parent;
  logic              take_left, child_up;
  logic [CountW-1:0] pick;
  logic [SlotW-1:0]  pick_slot;
  logic [CountW:0]   next_left;

  function automatic logic gt(logic [SlotW-1:0] a, logic [SlotW-1:0] b);
    return $signed(a[SlotW-1:TagW]) > $signed(b[SlotW-1:TagW]);
  endfunction

  function automatic logic [AddrW-1:0] adr(logic [CountW-1:0] p);
    logic [CountW-1:0] m;
    m = p - 1'b1;
    return m[AddrW-1:0];
  endfunction

  assign cmd_ready_o = state_q == SIdle && !rvalid_q;
  assign res_valid_o = rvalid_q;
  assign res_o       = res_q;
  assign lchild      = {pos_q, 1'b0};
  assign parent      = pos_q >> 1;

  // child choice: right child wins unless the left key is strictly larger or there is no right child
  assign take_left = (lchild == {1'b0, count_q}) || gt(left_q, rd_q);
  assign pick      = take_left ? lchild[CountW-1:0] : lchild[CountW-1:0] + 1'b1;
  assign pick_slot = take_left ? left_q : rd_q;
  assign child_up  = gt(pick_slot, node_q);
  assign next_left = {pick, 1'b0};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_comb begin
    rd_en = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = adr(pos_q); wr_data = node_q;
    case (state_q)
      // root is fetched while idle, a remove uses it
      SIdle: rd_en = 1'b1;
      SUpRd: begin
        if (pos_q == CountW'(1)) wr_en = 1'b1;
        else begin
          rd_en = 1'b1; rd_addr = adr(parent);
        end
      end
      SUpCmp: begin
        wr_en = 1'b1;
        if (gt(node_q, rd_q)) wr_data = rd_q;
      end
      SRmLast: begin
        rd_en = 1'b1; rd_addr = adr(count_q);
      end
      SRmGot: begin
        rd_en = 1'b1; rd_addr = AddrW'(1);
      end
      SDnRd: begin
        if (lchild > {1'b0, count_q}) wr_en = 1'b1;
        else begin
          rd_en = 1'b1; rd_addr = lchild[AddrW-1:0];
        end
      end
      SDnCmp: begin
        wr_en = 1'b1;
        if (child_up) begin
          wr_data = pick_slot;
          rd_en = 1'b1; rd_addr = adr(next_left[CountW-1:0]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      count_q  <= '0;
      pos_q    <= '0;
      node_q   <= '0;
      left_q   <= '0;
      res_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (rvalid_q && res_ready_i) rvalid_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (cmd_valid_i && cmd_ready_o) begin
            res_q.key <= '0; res_q.tag <= '0;
            node_q <= {cmd_i.key, cmd_i.tag};
            case (cmd_i.op)
              OpInsert: begin
                if (count_q == CountW'(Capacity)) begin
                  res_q.status <= StFull; state_q <= SDone;
                end else begin
                  res_q.status <= StOk;
                  count_q <= count_q + 1'b1;
                  pos_q   <= count_q + 1'b1;
                  state_q <= SUpRd;
                end
              end
              OpRemove: begin
                if (count_q == '0) begin
                  res_q.status <= StEmpty; state_q <= SDone;
                end else begin
                  res_q.status <= StOk; state_q <= SRmLast;
                end
              end
              OpClear: begin
                res_q.status <= StOk; count_q <= '0; state_q <= SDone;
              end
              default: begin
                res_q.status <= StOk; state_q <= SDone;
              end
            endcase
          end
        end
        SUpRd: state_q <= (pos_q == CountW'(1)) ? SDone : SUpCmp;
        SUpCmp: begin
          if (gt(node_q, rd_q)) begin
            pos_q <= parent; state_q <= SUpRd;
          end else state_q <= SDone;
        end
        SRmLast: begin
          // root arrived, last entry being read
          res_q.key <= rd_q[SlotW-1:TagW];
          res_q.tag <= rd_q[TagW-1:0];
          state_q <= SRmGot;
        end
        SRmGot: begin
          node_q  <= rd_q;
          count_q <= count_q - 1'b1;
          pos_q   <= CountW'(1);
          state_q <= SDnRd;
        end
        SDnRd: begin
          left_q  <= rd_q;
          state_q <= (lchild > {1'b0, count_q}) ? SDone : SDnCmp;
        end
        SDnCmp: begin
          if (child_up) begin
            pos_q <= pick; state_q <= SDnRd;
          end else state_q <= SDone;
        end
        default: begin
          rvalid_q <= 1'b1;
          res_q.now_empty <= count_q == '0;
          res_q.now_full  <= count_q == CountW'(Capacity);
          res_q.occupancy <= OccW'(count_q);
          state_q <= SIdle;
        end
      endcase
    end
  end

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SDone |-> !rvalid_q) else $error("result overwritten");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Capacity)) else $error("count beyond capacity");
  a_idle_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> state_q == SIdle) else $error("busy take");
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q && !res_ready_i |=> rvalid_q && $stable(res_q)) else $error("result dropped");

endmodule

FILE: rtl/binary_max_heap_priority_queue_core.sv
// top level of the binary max-heap priority queue
// depends on bmhpq_pkg, bmhpq_front, bmhpq_back
//
// usage: one input word per operation (insert, remove maximum, clear) on
// in_valid_i/in_ready_o, one result word per operation on
// out_valid_o/out_ready_i.
// clear, unused codes and refused words go straight to the result; insert
// climbs the entry one level at a time, remove sinks the last entry one
// level at a time; the sift sequencer has a single read and a single
// write port.
// one word is worked at a time: the next word starts in the back end the
// cycle after the previous result is taken.
// the front queue holds two words, so input is taken while the back end
// is busy or its result waits.
// reset empties the queue; the heap memory itself is not cleared.
// a stalled receiver holds the result and then the back end.
module binary_max_heap_priority_queue_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] new_key_i,
  input  logic [15:0]        new_tag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_key_o,
  output logic [15:0]        out_tag_o,
  output logic [1:0]         status_o,
  output logic               now_empty_o,
  output logic               now_full_o,
  output logic [10:0]        occupancy_o
);
  import bmhpq_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  bmhpq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .new_key_i,
    .new_tag_i, .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  bmhpq_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .res_valid_o(out_valid_o), .res_ready_i(out_ready_i),
    .res_o(res)
  );

  assign out_key_o   = res.key;
  assign out_tag_o   = res.tag;
  assign status_o    = res.status;
  assign now_empty_o = res.now_empty;
  assign now_full_o  = res.now_full;
  assign occupancy_o = res.occupancy;

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for binary_max_heap_priority_queue_core
// depends on bmhpq_pkg and the core; keeps its own heap to predict each result word
module tb_top;
  import bmhpq_pkg::*;

  localparam int HeapCap = 1024;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [15:0] tag;
  } in_word_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] tag;
    logic [1:0]  status;
    logic        now_empty;
    logic        now_full;
    logic [10:0] occupancy;
  } out_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = '0;
  logic signed [31:0] new_key_i = '0;
  logic [15:0] new_tag_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] out_key_o;
  logic [15:0] out_tag_o;
  logic [1:0] status_o;
  logic now_empty_o;
  logic now_full_o;
  logic [10:0] occupancy_o;

  binary_max_heap_priority_queue_core uut (.*);

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_sender = 1'b0;
  int        mismatches = 0;

  // predictor heap, 1-based
  logic [31:0] pq_key[HeapCap+1];
  logic [15:0] pq_tag[HeapCap+1];
  int          pq_count = 0;

  function automatic bit key_above(logic [31:0] a, logic [31:0] b);
    return $signed(a) > $signed(b);
  endfunction

  function automatic void pq_swap(int i, int j);
    logic [31:0] k;
    logic [15:0] t;
    k = pq_key[i]; pq_key[i] = pq_key[j]; pq_key[j] = k;
    t = pq_tag[i]; pq_tag[i] = pq_tag[j]; pq_tag[j] = t;
  endfunction

  function automatic out_word_t heap_predict(in_word_t w);
    out_word_t r;
    int pos, pick;
    r = '0;
    case (w.op)
      OpInsert: begin
        if (pq_count >= HeapCap) r.status = StFull;
        else begin
          pq_count++;
          pq_key[pq_count] = w.key;
          pq_tag[pq_count] = w.tag;
          pos = pq_count;
          while (pos > 1 && key_above(pq_key[pos], pq_key[pos/2])) begin
            pq_swap(pos, pos/2);
            pos = pos / 2;
          end
        end
      end
      OpRemove: begin
        if (pq_count == 0) r.status = StEmpty;
        else begin
          r.key = pq_key[1];
          r.tag = pq_tag[1];
          pq_key[1] = pq_key[pq_count];
          pq_tag[1] = pq_tag[pq_count];
          pq_count--;
          pos = 1;
          while (2*pos <= pq_count) begin
            pick = 2*pos;
            // on equal children the right one wins
            if (pick != pq_count && !key_above(pq_key[pick], pq_key[pick+1])) pick++;
            if (!key_above(pq_key[pick], pq_key[pos])) break;
            pq_swap(pos, pick);
            pos = pick;
          end
        end
      end
      OpClear: pq_count = 0;
      default: ;
    endcase
    r.now_empty = (pq_count == 0);
    r.now_full  = (pq_count == HeapCap);
    r.occupancy = pq_count[10:0];
    return r;
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // driver: holds valid and the word until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_words.push_back(heap_predict(pending_words.pop_front()));
      end
      if ((!in_valid_i || in_ready_o) && pending_words.size() > 0 && !hold_sender
          && ($urandom_range(99) >= send_idle_pct)) begin
        in_valid_i  <= 1'b1;
        operation_i <= pending_words[0].op;
        new_key_i   <= pending_words[0].key;
        new_tag_i   <= pending_words[0].tag;
      end else if (in_valid_i && in_ready_o) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: compares each result word with the oldest prediction
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatches++;
        end else begin
          e = expected_words.pop_front();
          if (out_key_o !== e.key) begin
            $error("out_key exp %0d got %0d", $signed(e.key), out_key_o); mismatches++;
          end
          if (out_tag_o !== e.tag) begin
            $error("out_tag exp %0h got %0h", e.tag, out_tag_o); mismatches++;
          end
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); mismatches++;
          end
          if (now_empty_o !== e.now_empty) begin
            $error("now_empty exp %0d got %0d", e.now_empty, now_empty_o); mismatches++;
          end
          if (now_full_o !== e.now_full) begin
            $error("now_full exp %0d got %0d", e.now_full, now_full_o); mismatches++;
          end
          if (occupancy_o !== e.occupancy) begin
            $error("occupancy exp %0d got %0d", e.occupancy, occupancy_o); mismatches++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_word_t mk(logic [1:0] op, logic [31:0] k, logic [15:0] t);
    in_word_t w;
    w.op = op; w.key = k; w.tag = t;
    return w;
  endfunction

  // small key range gives plenty of equal keys
  function automatic logic [31:0] rand_key();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(15) - 8;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int n, burst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, extremes, equal keys, unused code, clear
    pending_words.push_back(mk(OpRemove, 32'h0, 16'h0));
    pending_words.push_back(mk(OpInsert, 32'h8000_0000, 16'h0000));
    pending_words.push_back(mk(OpInsert, 32'h7fff_ffff, 16'hffff));
    pending_words.push_back(mk(OpInsert, 32'h0, 16'h1111));
    pending_words.push_back(mk(OpInsert, 32'h0, 16'h2222));
    pending_words.push_back(mk(OpInsert, 32'h0, 16'h3333));
    pending_words.push_back(mk(OpInsert, 32'hffff_ffff, 16'haaaa));
    pending_words.push_back(mk(OpNone, 32'hffff_ffff, 16'hffff));
    repeat (7) pending_words.push_back(mk(OpRemove, 32'hffff_ffff, 16'hffff));
    pending_words.push_back(mk(OpInsert, 32'h5, 16'h5));
    pending_words.push_back(mk(OpInsert, 32'h6, 16'h6));
    pending_words.push_back(mk(OpClear, 32'h0, 16'h0));
    pending_words.push_back(mk(OpRemove, 32'h0, 16'h0));
    wait_drained();

    // fill to capacity, then two inserts on full, then drain a little
    for (int i = 0; i < HeapCap + 2; i++)
      pending_words.push_back(mk(OpInsert, rand_key(), 16'($urandom)));
    repeat (20) pending_words.push_back(mk(OpRemove, 32'h0, 16'h0));
    pending_words.push_back(mk(OpInsert, rand_key(), 16'($urandom)));
    pending_words.push_back(mk(OpClear, 32'h0, 16'h0));
    wait_drained();

    // random phases under differing idle and stall rates
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      n = 0;
      while (n < 230) begin
        burst = $urandom_range(1, 40);
        // mostly inserts and mostly removes in alternating runs of 32 words
        for (int b = 0; b < burst; b++) begin
          int r;
          r = $urandom_range(99);
          if (r < 2) pending_words.push_back(mk(OpClear, $urandom, 16'($urandom)));
          else if (r < 4) pending_words.push_back(mk(OpNone, $urandom, 16'($urandom)));
          else if ((r < 60) ^ n[5])
            pending_words.push_back(mk(OpInsert, rand_key(), 16'($urandom)));
          else pending_words.push_back(mk(OpRemove, $urandom, 16'($urandom)));
          n++;
        end
      end
      // sender holds off until every result is back
      while (pending_words.size() > 0 || in_valid_i) @(posedge clk_i);
      hold_sender = 1'b1;
      while (expected_words.size() > 0) @(posedge clk_i);
      hold_sender = 1'b0;
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/bmhpq_pkg.sv
rtl/bmhpq_front.sv
rtl/bmhpq_back.sv
rtl/binary_max_heap_priority_queue_core.sv
tb/tb_top.sv
